>>> rtl/core/polyline_axis_interval_splitter_assert.svh
// ----------------------------------------------------------------------------
// polyline axis interval splitter assertion macros
// concurrent check helpers used by the splitter top module
// ----------------------------------------------------------------------------
`ifndef POLYLINE_AXIS_INTERVAL_SPLITTER_ASSERT_SVH
`define POLYLINE_AXIS_INTERVAL_SPLITTER_ASSERT_SVH

// same-cycle implication, skipped while in reset
`define PAIS_ASSERT_HOLD(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pais check failed");

// next-cycle implication, skipped while in reset
`define PAIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pais check failed");

`endif

>>> rtl/core/pais_pkg.sv
// ----------------------------------------------------------------------------
// pais_pkg
// widths, command codes and queue entry types of the interval splitter
// ----------------------------------------------------------------------------
package pais_pkg;

    localparam int COORD_W             = 32;
    localparam int SECTION_INDEX_BITS  = 16;
    localparam int POLYLINE_INDEX_BITS = 16;
    localparam int INTERVAL_INDEX_BITS = 24;

    localparam int PORT_COORD_W = 32;
    localparam int SECTION_W    = 32;
    localparam int POS_W        = 25;

    localparam logic BEGIN_FLAG = 1'b0;
    localparam logic END_FLAG   = 1'b1;

    // command queue, depth a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [COORD_W-1:0]      coord_t;
    typedef logic [INTERVAL_INDEX_BITS-1:0] interval_idx_t;
    typedef logic [SECTION_INDEX_BITS-1:0]  pair_idx_t;
    typedef logic [POLYLINE_INDEX_BITS-1:0] polyline_idx_t;

    typedef enum logic [1:0] {
        CMD_HORIZ,
        CMD_VERT,
        CMD_DIAG
    } cmd_kind_t;

    // one vertex pair, classified and sorted
    typedef struct packed {
        cmd_kind_t             kind;
        coord_t                x0;
        coord_t                y0;
        coord_t                x1;
        coord_t                y1;
        coord_t                x_lo;
        coord_t                x_hi;
        coord_t                y_lo;
        coord_t                y_hi;
        logic [SECTION_W-1:0]  section_id;
        interval_idx_t         base_count;
        logic                  index_overflow;
    } cmd_t;

endpackage

>>> rtl/core/pais_channels.sv
// ----------------------------------------------------------------------------
// pais channel interfaces
// valid/ready channels for vertices in and intervals out
// ----------------------------------------------------------------------------
interface pais_point_if;
    logic                                            valid;
    logic                                            ready;
    logic signed [pais_pkg::PORT_COORD_W-1:0]        point_x;
    logic signed [pais_pkg::PORT_COORD_W-1:0]        point_y;
    logic                                            last_point;

    modport source (output valid, point_x, point_y, last_point, input ready);
    modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

interface pais_interval_if;
    logic                                            valid;
    logic                                            ready;
    logic [pais_pkg::SECTION_W-1:0]                  section_id;
    logic [pais_pkg::POS_W-1:0]                      begin_pos_id;
    logic [pais_pkg::POS_W-1:0]                      end_pos_id;
    logic signed [pais_pkg::PORT_COORD_W-1:0]        begin_x;
    logic signed [pais_pkg::PORT_COORD_W-1:0]        begin_y;
    logic signed [pais_pkg::PORT_COORD_W-1:0]        end_x;
    logic signed [pais_pkg::PORT_COORD_W-1:0]        end_y;
    logic                                            index_overflow;
    logic                                            last_of_run;

    modport source (output valid, section_id, begin_pos_id, end_pos_id, begin_x, begin_y,
                    end_x, end_y, index_overflow, last_of_run, input ready);
    modport sink   (input valid, section_id, begin_pos_id, end_pos_id, begin_x, begin_y,
                    end_x, end_y, index_overflow, last_of_run, output ready);
endinterface

>>> rtl/core/pais_front.sv
// ----------------------------------------------------------------------------
// pais_front
// takes vertices, tracks polyline state, pushes one command per non-repeat pair
// ----------------------------------------------------------------------------
module pais_front (
    input  logic               clk,
    input  logic               rst_n,
    pais_point_if.sink         vertex,
    input  logic               queue_full,
    output logic               push,
    output pais_pkg::cmd_t     push_cmd
);

    pais_pkg::coord_t        prev_x_reg, prev_x_next;
    pais_pkg::coord_t        prev_y_reg, prev_y_next;
    logic                    have_prev_reg, have_prev_next;
    pais_pkg::polyline_idx_t poly_reg, poly_next;
    pais_pkg::pair_idx_t     pair_reg, pair_next;
    pais_pkg::interval_idx_t count_reg, count_next;

    pais_pkg::coord_t                       x, y;
    logic                                   accept, diff_x, diff_y, emit;
    logic [pais_pkg::INTERVAL_INDEX_BITS:0] count_sum;
    logic [2:0]                             n_out;
    logic                                   pair_wrap, poly_wrap;

    assign vertex.ready = !queue_full;
    assign accept       = vertex.valid && vertex.ready;

    assign x = pais_pkg::coord_t'(vertex.point_x[pais_pkg::COORD_W-1:0]);
    assign y = pais_pkg::coord_t'(vertex.point_y[pais_pkg::COORD_W-1:0]);

    assign diff_x = (x != prev_x_reg);
    assign diff_y = (y != prev_y_reg);
    assign emit   = have_prev_reg && (diff_x || diff_y);

    always_comb
    begin
        if (!emit)
            n_out = 3'd0;
        else if (diff_x && diff_y)
            n_out = 3'd4;
        else
            n_out = 3'd1;
    end

    // counter wrap anywhere in this pair's run
    assign count_sum = {1'b0, count_reg} + (pais_pkg::INTERVAL_INDEX_BITS + 1)'(n_out);
    assign pair_wrap = have_prev_reg && (pair_reg == '1);
    assign poly_wrap = vertex.last_point && (poly_reg == '1);

    assign push = accept && emit;

    always_comb
    begin
        push_cmd.kind = pais_pkg::CMD_DIAG;
        if (!diff_y)
            push_cmd.kind = pais_pkg::CMD_HORIZ;
        else if (!diff_x)
            push_cmd.kind = pais_pkg::CMD_VERT;
        push_cmd.x0   = prev_x_reg;
        push_cmd.y0   = prev_y_reg;
        push_cmd.x1   = x;
        push_cmd.y1   = y;
        push_cmd.x_lo = (x < prev_x_reg) ? x : prev_x_reg;
        push_cmd.x_hi = (x < prev_x_reg) ? prev_x_reg : x;
        push_cmd.y_lo = (y < prev_y_reg) ? y : prev_y_reg;
        push_cmd.y_hi = (y < prev_y_reg) ? prev_y_reg : y;
        push_cmd.section_id = (pais_pkg::SECTION_W'(poly_reg) << pais_pkg::SECTION_INDEX_BITS)
                            | pais_pkg::SECTION_W'(pair_reg);
        push_cmd.base_count = count_reg;
        push_cmd.index_overflow =
            count_sum[pais_pkg::INTERVAL_INDEX_BITS] || pair_wrap || poly_wrap;
    end

    always_comb
    begin
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        have_prev_next = have_prev_reg;
        poly_next      = poly_reg;
        pair_next      = pair_reg;
        count_next     = count_reg;
        if (accept)
        begin
            prev_x_next    = x;
            prev_y_next    = y;
            have_prev_next = !vertex.last_point;
            count_next     = count_sum[pais_pkg::INTERVAL_INDEX_BITS-1:0];
            if (have_prev_reg)
                pair_next = pair_reg + 1'b1;
            if (vertex.last_point)
            begin
                pair_next = '0;
                poly_next = poly_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prev_x_reg <= prev_x_next;
        prev_y_reg <= prev_y_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            poly_reg      <= '0;
            pair_reg      <= '0;
            count_reg     <= '0;
        end
        else
        begin
            have_prev_reg <= have_prev_next;
            poly_reg      <= poly_next;
            pair_reg      <= pair_next;
            count_reg     <= count_next;
        end
    end

endmodule

>>> rtl/core/pais_queue.sv
// ----------------------------------------------------------------------------
// pais_queue
// short command fifo between the front and back parts
// ----------------------------------------------------------------------------
module pais_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  pais_pkg::cmd_t     push_cmd,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output pais_pkg::cmd_t     head_cmd
);

    pais_pkg::cmd_t                     mem_reg [pais_pkg::QUEUE_DEPTH];
    logic [pais_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [pais_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [pais_pkg::QUEUE_CNT_W-1:0]   count_reg, count_next;

    assign full       = (count_reg == pais_pkg::QUEUE_CNT_W'(pais_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/core/pais_back.sv
// ----------------------------------------------------------------------------
// pais_back
// expands the head command into intervals through the output register
// ----------------------------------------------------------------------------
module pais_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  pais_pkg::cmd_t     head_cmd,
    output logic               pop,
    pais_interval_if.source    interval
);

    logic [1:0]              step_reg, step_next;
    logic                    valid_reg, valid_next;

    logic [pais_pkg::SECTION_W-1:0] section_reg;
    pais_pkg::interval_idx_t        pos_reg, pos_next;
    pais_pkg::coord_t               bx_reg, by_reg, ex_reg, ey_reg;
    pais_pkg::coord_t               bx_next, by_next, ex_next, ey_next;
    logic                           ovf_reg, last_reg, last_next;

    logic load;

    assign load = head_valid && (!valid_reg || interval.ready);
    assign pop  = load && last_next;

    always_comb
    begin
        last_next = 1'b1;
        bx_next   = head_cmd.x_lo;
        by_next   = head_cmd.y0;
        ex_next   = head_cmd.x_hi;
        ey_next   = head_cmd.y0;
        case (head_cmd.kind)
            pais_pkg::CMD_HORIZ:
            begin
                bx_next = head_cmd.x_lo;
            end
            pais_pkg::CMD_VERT:
            begin
                bx_next = head_cmd.x0;
                by_next = head_cmd.y_lo;
                ex_next = head_cmd.x0;
                ey_next = head_cmd.y_hi;
            end
            pais_pkg::CMD_DIAG:
            begin
                last_next = (step_reg == 2'd3);
                case (step_reg)
                    2'd0:
                    begin
                        by_next = head_cmd.y0;
                    end
                    2'd1:
                    begin
                        by_next = head_cmd.y1;
                        ey_next = head_cmd.y1;
                    end
                    2'd2:
                    begin
                        bx_next = head_cmd.x0;
                        by_next = head_cmd.y_lo;
                        ex_next = head_cmd.x0;
                        ey_next = head_cmd.y_hi;
                    end
                    default:
                    begin
                        bx_next = head_cmd.x1;
                        by_next = head_cmd.y_lo;
                        ex_next = head_cmd.x1;
                        ey_next = head_cmd.y_hi;
                    end
                endcase
            end
            default:
            begin
                last_next = 1'b1;
            end
        endcase
    end

    assign pos_next  = head_cmd.base_count + pais_pkg::INTERVAL_INDEX_BITS'(step_reg);

    always_comb
    begin
        step_next  = step_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            step_next  = last_next ? 2'd0 : step_reg + 2'd1;
        end
        else if (interval.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            section_reg <= head_cmd.section_id;
            pos_reg     <= pos_next;
            bx_reg      <= bx_next;
            by_reg      <= by_next;
            ex_reg      <= ex_next;
            ey_reg      <= ey_next;
            ovf_reg     <= head_cmd.index_overflow;
            last_reg    <= last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    assign interval.valid          = valid_reg;
    assign interval.section_id     = section_reg;
    assign interval.begin_pos_id   = pais_pkg::POS_W'({pos_reg, pais_pkg::BEGIN_FLAG});
    assign interval.end_pos_id     = pais_pkg::POS_W'({pos_reg, pais_pkg::END_FLAG});
    assign interval.begin_x        = pais_pkg::PORT_COORD_W'(bx_reg);
    assign interval.begin_y        = pais_pkg::PORT_COORD_W'(by_reg);
    assign interval.end_x          = pais_pkg::PORT_COORD_W'(ex_reg);
    assign interval.end_y          = pais_pkg::PORT_COORD_W'(ey_reg);
    assign interval.index_overflow = ovf_reg;
    assign interval.last_of_run    = last_reg;

endmodule

>>> rtl/core/polyline_axis_interval_splitter.sv
// ----------------------------------------------------------------------------
// polyline_axis_interval_splitter
// splits polyline segments into sorted axis-aligned intervals
// ----------------------------------------------------------------------------
//
//  channel    dir  transaction
//  ---------  ---  ---------------------------------------------------------
//  vertex     in   point_x, point_y, last_point: one polyline vertex
//  interval   out  section_id, pos ids, sorted ends, overflow, last_of_run
//
//  a vertex is taken every cycle while the two-entry command queue has room
//  a diagonal pair gives four intervals, an axis pair one, a first or repeated
//  vertex none; the single output register sets one interval a cycle while the
//  receiver is ready; a pair's first interval passes the queue, then that register
//  reset clears counters, queue and output valid; stored coordinates are not reset
//  a stalled interval channel fills the queue, then drops vertex.ready
//
`include "polyline_axis_interval_splitter_assert.svh"

module polyline_axis_interval_splitter (
    input  logic              clk,
    input  logic              rst_n,
    pais_point_if.sink        vertex,
    pais_interval_if.source   interval
);

    // front to queue
    logic               push;
    pais_pkg::cmd_t     push_cmd;
    logic               queue_full;

    // queue to back
    logic               pop;
    logic               head_valid;
    pais_pkg::cmd_t     head_cmd;

    // classification and index bookkeeping
    pais_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .vertex     (vertex),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // decouples vertex intake from interval output
    pais_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // one to four intervals per command
    pais_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .interval   (interval)
    );

    // ends always sorted along both axes
    `PAIS_ASSERT_HOLD(a_sorted_ends, clk, rst_n, interval.valid,
        (interval.begin_x <= interval.end_x) && (interval.begin_y <= interval.end_y))

    // a run never breaks up: the next interval follows at once
    `PAIS_ASSERT_NEXT(a_run_contiguous, clk, rst_n,
        interval.valid && interval.ready && !interval.last_of_run, interval.valid)

    // section and overflow flag shared by all intervals of a run
    `PAIS_ASSERT_NEXT(a_run_shared, clk, rst_n,
        interval.valid && interval.ready && !interval.last_of_run,
        (interval.section_id == $past(interval.section_id))
            && (interval.index_overflow == $past(interval.index_overflow)))

endmodule

>>> verif/polyline_axis_interval_splitter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_axis_interval_splitter_tb
// feeds polyline vertices through the valid/ready vertex channel and checks
// every interval against a cycle-free predictor of the splitter, under three
// mixes of sender and receiver stalls
// ----------------------------------------------------------------------------
module polyline_axis_interval_splitter_tb;

    typedef logic signed [pais_pkg::PORT_COORD_W-1:0] port_coord_t;

    // one interval transaction as seen on the output channel
    typedef struct packed {
        logic [pais_pkg::SECTION_W-1:0] section_id;
        logic [pais_pkg::POS_W-1:0]     begin_pos_id;
        logic [pais_pkg::POS_W-1:0]     end_pos_id;
        port_coord_t                    begin_x;
        port_coord_t                    begin_y;
        port_coord_t                    end_x;
        port_coord_t                    end_y;
        logic                           index_overflow;
        logic                           last_of_run;
    } interval_rec_t;

    localparam port_coord_t COORD_MIN = {1'b1, {(pais_pkg::PORT_COORD_W-1){1'b0}}};
    localparam port_coord_t COORD_MAX = {1'b0, {(pais_pkg::PORT_COORD_W-1){1'b1}}};

    // intervals pass the command queue and output register; leave generous slack
    localparam int SETTLE_CYCLES = 16;

    logic clk = 1'b0;
    logic rst_n;

    pais_point_if    vertex_ch ();
    pais_interval_if interval_ch ();

    polyline_axis_interval_splitter i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .vertex   (vertex_ch),
        .interval (interval_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // stall mix, percent of cycles idle on each side
    int send_idle_pct;
    int recv_idle_pct;

    // splitter state as the predictor tracks it
    pais_pkg::coord_t        prev_x;
    pais_pkg::coord_t        prev_y;
    logic                    have_prev;
    pais_pkg::polyline_idx_t polyline_idx;
    pais_pkg::pair_idx_t     pair_idx;
    pais_pkg::interval_idx_t interval_cnt;

    // per-vertex scratch shared with next_interval
    logic [pais_pkg::SECTION_W-1:0] step_section;
    logic                           step_wrap;

    interval_rec_t expected_intervals[$];

    int error_count;
    int vertices_sent;
    int intervals_checked;
    int overflow_seen;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // builds one interval and advances the running interval counter
    function automatic interval_rec_t next_interval(pais_pkg::coord_t bx,
                                                   pais_pkg::coord_t by,
                                                   pais_pkg::coord_t ex,
                                                   pais_pkg::coord_t ey);
        interval_rec_t r;
        logic [63:0]   pos;
        pos              = 64'(interval_cnt) << 1;
        r.section_id     = step_section;
        r.begin_pos_id   = pos[pais_pkg::POS_W-1:0];
        pos[0]           = pais_pkg::END_FLAG;
        r.end_pos_id     = pos[pais_pkg::POS_W-1:0];
        // coordinates are sign-extended from the core width to the port width
        r.begin_x        = port_coord_t'(bx);
        r.begin_y        = port_coord_t'(by);
        r.end_x          = port_coord_t'(ex);
        r.end_y          = port_coord_t'(ey);
        r.index_overflow = 1'b0;
        r.last_of_run    = 1'b0;
        interval_cnt     = interval_cnt + 1'b1;
        if (interval_cnt == '0)
            step_wrap = 1'b1;
        return r;
    endfunction

    // works out the intervals one accepted vertex causes and queues them
    task automatic predict_intervals(input port_coord_t px, input port_coord_t py,
                                     input logic last);
        pais_pkg::coord_t x;
        pais_pkg::coord_t y;
        pais_pkg::coord_t x_lo;
        pais_pkg::coord_t x_hi;
        pais_pkg::coord_t y_lo;
        pais_pkg::coord_t y_hi;
        logic [63:0]      sect;
        interval_rec_t    batch[$];
        // only the low core-width bits of each coordinate count
        x            = px[pais_pkg::COORD_W-1:0];
        y            = py[pais_pkg::COORD_W-1:0];
        step_wrap    = 1'b0;
        sect         = (64'(polyline_idx) << pais_pkg::SECTION_INDEX_BITS) + 64'(pair_idx);
        step_section = sect[pais_pkg::SECTION_W-1:0];

        if (have_prev)
        begin
            x_lo = (x < prev_x) ? x : prev_x;
            x_hi = (x < prev_x) ? prev_x : x;
            y_lo = (y < prev_y) ? y : prev_y;
            y_hi = (y < prev_y) ? prev_y : y;
            if (prev_x != x && prev_y != y)
            begin
                // diagonal: horizontal at y0, at y1, vertical at x0, at x1
                batch = {batch, next_interval(x_lo, prev_y, x_hi, prev_y)};
                batch = {batch, next_interval(x_lo, y, x_hi, y)};
                batch = {batch, next_interval(prev_x, y_lo, prev_x, y_hi)};
                batch = {batch, next_interval(x, y_lo, x, y_hi)};
            end
            else if (prev_x != x)
                batch = {batch, next_interval(x_lo, prev_y, x_hi, prev_y)};
            else if (prev_y != y)
                batch = {batch, next_interval(prev_x, y_lo, prev_x, y_hi)};
            // a repeated vertex emits nothing but still takes a pair index
            pair_idx = pair_idx + 1'b1;
            if (pair_idx == '0)
                step_wrap = 1'b1;
        end

        prev_x    = x;
        prev_y    = y;
        have_prev = 1'b1;

        if (last)
        begin
            polyline_idx = polyline_idx + 1'b1;
            if (polyline_idx == '0)
                step_wrap = 1'b1;
            pair_idx  = '0;
            have_prev = 1'b0;
        end

        for (int k = 0; k < batch.size(); k++)
        begin
            batch[k].index_overflow = step_wrap;
            batch[k].last_of_run    = (k == batch.size() - 1);
            expected_intervals      = {expected_intervals, batch[k]};
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // one vertex transaction; valid stays high when the next call has no gap
    task automatic send_vertex(input port_coord_t x, input port_coord_t y,
                               input logic last);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            vertex_ch.valid = 1'b0;
            @(negedge clk);
        end
        vertex_ch.valid      = 1'b1;
        vertex_ch.point_x    = x;
        vertex_ch.point_y    = y;
        vertex_ch.last_point = last;
        do
            @(posedge clk);
        while (vertex_ch.ready !== 1'b1);
        predict_intervals(x, y, last);
        vertices_sent++;
    endtask

    // sender holds off until every queued interval has come out
    task automatic wait_for_intervals();
        @(negedge clk);
        vertex_ch.valid = 1'b0;
        while (expected_intervals.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // mostly full-range values, some near zero, some at the extremes
    function automatic port_coord_t rand_coord();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return port_coord_t'($urandom);
        if (sel < 8)
            return port_coord_t'($urandom_range(0, 40)) - 20;
        case ($urandom_range(0, 3))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // horizontal and vertical pairs in both directions, plus a repeated vertex
    task automatic test_axis_pairs();
        send_vertex(0, 0, 1'b0);
        send_vertex(5, 0, 1'b0);
        send_vertex(5, -3, 1'b0);
        send_vertex(-2, -3, 1'b0);
        send_vertex(-2, -3, 1'b0);
        send_vertex(-2, 10, 1'b1);
    endtask

    // diagonals with ends that need swapping on both axes
    task automatic test_diagonal_pairs();
        send_vertex(10, 20, 1'b0);
        send_vertex(-7, 3, 1'b0);
        send_vertex(100, 50, 1'b0);
        send_vertex(99, 49, 1'b1);
    endtask

    // coordinates at the signed limits and all-ones / all-zeros patterns
    task automatic test_extreme_coords();
        send_vertex(COORD_MIN, COORD_MAX, 1'b0);
        send_vertex(COORD_MAX, COORD_MIN, 1'b0);
        send_vertex(COORD_MAX, COORD_MAX, 1'b0);
        send_vertex(COORD_MIN, COORD_MAX, 1'b0);
        send_vertex(-1, 0, 1'b0);
        send_vertex(0, -1, 1'b1);
    endtask

    // single-vertex polyline and a polyline made only of one repeated point
    task automatic test_degenerate_polylines();
        send_vertex(7, 7, 1'b1);
        send_vertex(3, 3, 1'b0);
        send_vertex(3, 3, 1'b1);
    endtask

    // random polylines: mostly well-formed, with single vertices and repeats
    task automatic test_random_polylines(input int n_items);
        int          sent;
        int          len;
        int          mode;
        port_coord_t cx;
        port_coord_t cy;
        sent = 0;
        while (sent < n_items)
        begin
            len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 8);
            cx  = rand_coord();
            cy  = rand_coord();
            for (int v = 0; v < len && sent < n_items; v++)
            begin
                if (v > 0)
                begin
                    mode = $urandom_range(0, 99);
                    if (mode < 50)
                    begin
                        cx = rand_coord();
                        cy = rand_coord();
                    end
                    else if (mode < 70)
                        cx = rand_coord();
                    else if (mode < 90)
                        cy = rand_coord();
                    // else repeat the previous vertex
                end
                send_vertex(cx, cy, (v == len - 1) || (sent == n_items - 1));
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------

    function automatic string fmt_interval(interval_rec_t r);
        return $sformatf("sect=%h pos=%h/%h begin=(%0d,%0d) end=(%0d,%0d) ovf=%b last=%b",
                         r.section_id, r.begin_pos_id, r.end_pos_id, r.begin_x,
                         r.begin_y, r.end_x, r.end_y, r.index_overflow, r.last_of_run);
    endfunction

    // receiver stalls, new decision every falling edge
    always @(negedge clk)
        interval_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);

    interval_rec_t got_interval;
    interval_rec_t want_interval;

    // compare each interval transaction with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && interval_ch.valid === 1'b1 && interval_ch.ready === 1'b1)
        begin
            got_interval.section_id     = interval_ch.section_id;
            got_interval.begin_pos_id   = interval_ch.begin_pos_id;
            got_interval.end_pos_id     = interval_ch.end_pos_id;
            got_interval.begin_x        = interval_ch.begin_x;
            got_interval.begin_y        = interval_ch.begin_y;
            got_interval.end_x          = interval_ch.end_x;
            got_interval.end_y          = interval_ch.end_y;
            got_interval.index_overflow = interval_ch.index_overflow;
            got_interval.last_of_run    = interval_ch.last_of_run;
            if (expected_intervals.size() == 0)
            begin
                $display("%0t: unexpected interval, actual %s", $time,
                         fmt_interval(got_interval));
                error_count++;
            end
            else
            begin
                want_interval = expected_intervals.pop_front();
                if (got_interval !== want_interval)
                begin
                    $display("%0t: interval mismatch, expected %s", $time,
                             fmt_interval(want_interval));
                    $display("%0t:                      actual %s", $time,
                             fmt_interval(got_interval));
                    error_count++;
                end
            end
            if (interval_ch.index_overflow === 1'b1)
                overflow_seen++;
            intervals_checked++;
        end
    end

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------

    initial
    begin
        vertex_ch.valid      = 1'b0;
        vertex_ch.point_x    = '0;
        vertex_ch.point_y    = '0;
        vertex_ch.last_point = 1'b0;
        interval_ch.ready    = 1'b0;
        rst_n                = 1'b0;
        send_idle_pct        = 18;
        recv_idle_pct        = 57;
        prev_x               = '0;
        prev_y               = '0;
        have_prev            = 1'b0;
        polyline_idx         = '0;
        pair_idx             = '0;
        interval_cnt         = '0;
        error_count          = 0;
        vertices_sent        = 0;
        intervals_checked    = 0;
        overflow_seen        = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // slow receiver, occasional sender gaps
        test_axis_pairs();
        test_diagonal_pairs();
        test_extreme_coords();
        test_degenerate_polylines();
        wait_for_intervals();
        test_random_polylines(35);
        wait_for_intervals();

        // slow sender, mostly ready receiver
        send_idle_pct = 57;
        recv_idle_pct = 18;
        test_random_polylines(30);
        wait_for_intervals();

        // full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_polylines(26);
        wait_for_intervals();

        $display("run covered %0d vertex transactions and %0d interval transactions,",
                 vertices_sent, intervals_checked);
        $display("axis, diagonal, repeated and single vertices, %0d with index overflow",
                 overflow_seen);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // guard against a hung handshake
    initial
    begin
        #10_000_000;
        $display("error: run timed out with %0d intervals outstanding",
                 expected_intervals.size());
        $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/pais_pkg.sv
rtl/core/pais_channels.sv
rtl/core/pais_front.sv
rtl/core/pais_queue.sv
rtl/core/pais_back.sv
rtl/core/polyline_axis_interval_splitter.sv
verif/polyline_axis_interval_splitter_tb.sv
